FILE: rtl/gcw_pkg.sv
// ----------------------------------------------------------------------------
// gcw_pkg
// Shared types, constants and helpers for the grapheme cell width tracker.
// ----------------------------------------------------------------------------
package gcw_pkg;

    // Segmenter states.
    typedef enum logic [2:0] {
        ST_START      = 3'd0,
        ST_MAYBE_FLAG = 3'd1,
        ST_BEGIN_EMO  = 3'd2,
        ST_EMO_SEQ    = 3'd3,
        ST_EMO_ZWJ    = 3'd4,
        ST_RUN        = 3'd5
    } seg_state_t;

    // Register indexes of the configuration port.
    localparam logic CFG_CTRL_WIDTH  = 1'b0;
    localparam logic CFG_EMOJI_EN    = 1'b1;

    // Codepoints the segmenter looks for.
    localparam logic [20:0] CP_RI_FIRST  = 21'h1F1E6;
    localparam logic [20:0] CP_RI_LAST   = 21'h1F1FF;
    localparam logic [20:0] CP_WAVY_DASH = 21'h03030;
    localparam logic [20:0] CP_PART_ALT  = 21'h0303D;
    localparam logic [20:0] CP_CONGRATS  = 21'h03297;
    localparam logic [20:0] CP_SECRET    = 21'h03299;
    localparam logic [20:0] CP_ZWJ       = 21'h0200D;
    localparam logic [20:0] CP_FEMALE    = 21'h02640;
    localparam logic [20:0] CP_MALE      = 21'h02642;

    // One input request.
    typedef struct packed {
        logic [20:0] codepoint;
        logic [2:0]  cell_width;
        logic        emoji_flag;
        logic        unqualified_half_flag;
        logic        variant_selector_flag;
    } item_t;

    // Segmenter state carried from one request to the next.
    typedef struct packed {
        seg_state_t  state;
        logic [2:0]  last_finished_width;
        logic [2:0]  running_width;
        logic [2:0]  running_width_before;
        logic        pending_unqualified;
        logic        pending_wide_special;
    } tracker_t;

    // Configuration seen by the segmenter.
    typedef struct packed {
        logic [2:0] control_char_width;
        logic       color_emoji_enable;
    } cfg_t;

    // One result.
    typedef struct packed {
        logic       new_grapheme;
        logic [2:0] finished_width;
        logic [2:0] current_width;
        logic [2:0] current_width_before;
    } result_t;

    // Widen a grapheme to at least two cells.
    function automatic logic [2:0] at_least_two(input logic [2:0] w);
        return (w < 3'd2) ? 3'd2 : w;
    endfunction

endpackage

FILE: rtl/gcw_seg_logic.sv
// ----------------------------------------------------------------------------
// gcw_seg_logic
// Next-state and result logic of the grapheme segmenter for one codepoint.
// ----------------------------------------------------------------------------
module gcw_seg_logic
(
    input  gcw_pkg::item_t    item,
    input  gcw_pkg::tracker_t cur,
    input  gcw_pkg::cfg_t     cfg,
    output gcw_pkg::tracker_t nxt,
    output gcw_pkg::result_t  res
);

    logic       is_ctrl;
    logic [2:0] w;
    logic [2:0] prior_width;
    logic       is_ri;
    logic       is_special;
    logic       vs;
    logic       emo;
    logic       unq;

    // Decode the incoming codepoint classes.
    assign is_ctrl     = item.cell_width[2];
    assign w           = is_ctrl ? 3'd0 : {1'b0, item.cell_width[1:0]};
    assign prior_width = cur.running_width;
    assign vs          = item.variant_selector_flag;
    assign emo         = item.emoji_flag;
    assign unq         = item.unqualified_half_flag;
    assign is_ri       = (item.codepoint >= gcw_pkg::CP_RI_FIRST) &&
                         (item.codepoint <= gcw_pkg::CP_RI_LAST);
    assign is_special  = (item.codepoint == gcw_pkg::CP_WAVY_DASH) ||
                         (item.codepoint == gcw_pkg::CP_PART_ALT) ||
                         (item.codepoint == gcw_pkg::CP_CONGRATS) ||
                         (item.codepoint == gcw_pkg::CP_SECRET);

    // Segmenter: continue the grapheme, or close it and open a new one.
    always_comb
    begin
        logic done;
        logic to_seq;
        logic started;

        nxt     = cur;
        done    = 1'b0;
        to_seq  = 1'b0;
        started = 1'b0;

        if (item.codepoint == 21'd0)
        begin
            // NUL closes the grapheme and stands alone.
            nxt.state                = gcw_pkg::ST_START;
            nxt.last_finished_width  = cur.running_width;
            nxt.running_width        = cfg.control_char_width;
            nxt.running_width_before = 3'd0;
            started                  = 1'b1;
            done                     = 1'b1;
        end
        else
        begin
            case (cur.state)
                gcw_pkg::ST_MAYBE_FLAG:
                begin
                    nxt.state = gcw_pkg::ST_START;
                    if (is_ri)
                    begin
                        nxt.running_width_before = prior_width;
                        nxt.running_width        = 3'd2;
                        done                     = 1'b1;
                    end
                end
                gcw_pkg::ST_BEGIN_EMO:
                begin
                    nxt.state = gcw_pkg::ST_EMO_SEQ;
                    if (cur.pending_unqualified && vs)
                    begin
                        nxt.running_width_before = prior_width;
                        nxt.running_width        = gcw_pkg::at_least_two(cur.running_width);
                        nxt.pending_unqualified  = 1'b0;
                        nxt.pending_wide_special = 1'b0;
                        done                     = 1'b1;
                    end
                    else
                    begin
                        if (cur.pending_wide_special)
                        begin
                            nxt.running_width_before = prior_width;
                            nxt.running_width =
                                gcw_pkg::at_least_two(cur.running_width);
                        end
                        to_seq = 1'b1;
                    end
                end
                gcw_pkg::ST_EMO_SEQ:
                begin
                    to_seq = 1'b1;
                end
                gcw_pkg::ST_EMO_ZWJ:
                begin
                    if (!emo && !unq && (item.codepoint != gcw_pkg::CP_FEMALE) &&
                        (item.codepoint != gcw_pkg::CP_MALE))
                    begin
                        nxt.state = gcw_pkg::ST_START;
                    end
                    else
                    begin
                        nxt.state = gcw_pkg::ST_EMO_SEQ;
                        done      = 1'b1;
                    end
                end
                gcw_pkg::ST_RUN:
                begin
                    if (!is_ctrl && (w == 3'd0))
                    begin
                        done = 1'b1;
                    end
                    else if (cfg.color_emoji_enable && vs)
                    begin
                        nxt.running_width_before = prior_width;
                        nxt.running_width        = gcw_pkg::at_least_two(cur.running_width);
                        done                     = 1'b1;
                    end
                    else
                    begin
                        nxt.state = gcw_pkg::ST_START;
                    end
                end
                default:
                begin
                    nxt.state = gcw_pkg::ST_START;
                end
            endcase

            // Inside an emoji sequence: selectors and ZWJ extend it.
            if (!done && to_seq)
            begin
                if (vs)
                begin
                    nxt.running_width_before = prior_width;
                    nxt.running_width        = gcw_pkg::at_least_two(nxt.running_width);
                    done                     = 1'b1;
                end
                else if (item.codepoint == gcw_pkg::CP_ZWJ)
                begin
                    nxt.running_width_before = prior_width;
                    nxt.running_width        = gcw_pkg::at_least_two(nxt.running_width);
                    nxt.state                = gcw_pkg::ST_EMO_ZWJ;
                    done                     = 1'b1;
                end
                else
                begin
                    nxt.state = gcw_pkg::ST_START;
                end
            end

            // Close the current grapheme and start a new one.
            if (!done)
            begin
                nxt.last_finished_width  = nxt.running_width;
                nxt.running_width_before = 3'd0;
                started                  = 1'b1;
                if (is_ctrl)
                begin
                    nxt.running_width = cfg.control_char_width;
                    nxt.state         = gcw_pkg::ST_START;
                end
                else
                begin
                    nxt.running_width = w;
                    nxt.state         = gcw_pkg::ST_RUN;
                    if (cfg.color_emoji_enable && (w != 3'd0))
                    begin
                        if (is_ri)
                        begin
                            nxt.state = gcw_pkg::ST_MAYBE_FLAG;
                        end
                        else if (unq || emo)
                        begin
                            nxt.state                = gcw_pkg::ST_BEGIN_EMO;
                            nxt.pending_unqualified  = unq;
                            nxt.pending_wide_special = is_special;
                        end
                        else if (vs)
                        begin
                            nxt.running_width = gcw_pkg::at_least_two(w);
                            nxt.state         = gcw_pkg::ST_EMO_SEQ;
                        end
                    end
                end
            end
        end

        res.new_grapheme         = started;
        res.finished_width       = nxt.last_finished_width;
        res.current_width        = nxt.running_width;
        res.current_width_before = nxt.running_width_before;
    end

endmodule

FILE: rtl/grapheme_cell_width_tracker.sv
// ----------------------------------------------------------------------------
// grapheme_cell_width_tracker
// Groups a codepoint stream into displayed graphemes and tracks cell widths.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid / in_stall) carries one codepoint request
//   with its width and class flags. Each accepted request yields exactly one
//   result on the output channel (out_valid / out_stall), in order.
//   A request is held in an input register; when the result register is free
//   or taken, the segmenter logic updates the grapheme state and loads the
//   result register, which raises out_valid. Throughput is one request per
//   cycle while the receiver does not stall; the state update is a single
//   pass of logic between the input register and the result register. When
//   the receiver stalls, the result register holds its request and the input
//   register fills; in_stall then rises until the result is taken.
//   Configuration (cfg_write / cfg_index / cfg_data) is to be written by the
//   user only while the block is idle; the block itself does not enforce
//   this. Reset sets control_char_width and color_emoji_enable to 1, returns
//   the segmenter to its start state and clears its widths.
// ----------------------------------------------------------------------------
module grapheme_cell_width_tracker
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_write,
    input  logic              cfg_index,
    input  logic [2:0]        cfg_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic [20:0]       codepoint,
    input  logic signed [2:0] cell_width,
    input  logic              emoji_flag,
    input  logic              unqualified_half_flag,
    input  logic              variant_selector_flag,

    output logic              out_valid,
    input  logic              out_stall,
    output logic              new_grapheme,
    output logic [2:0]        finished_width,
    output logic [2:0]        current_width,
    output logic [2:0]        current_width_before
);

    gcw_pkg::cfg_t     cfg_reg;
    gcw_pkg::tracker_t trk_reg;
    gcw_pkg::tracker_t trk_next;
    gcw_pkg::item_t    item_reg;
    logic              item_valid_reg;
    gcw_pkg::result_t  res_reg;
    gcw_pkg::result_t  res_next;
    logic              out_valid_reg;
    logic              advance;
    logic              accept;

    // Handshake: the stage moves when the result register is free or taken.
    assign advance  = item_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = item_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.control_char_width <= 3'd1;
            cfg_reg.color_emoji_enable <= 1'b1;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                gcw_pkg::CFG_CTRL_WIDTH: cfg_reg.control_char_width <= cfg_data;
                gcw_pkg::CFG_EMOJI_EN:   cfg_reg.color_emoji_enable <= cfg_data[0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Input register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.codepoint             <= codepoint;
            item_reg.cell_width            <= cell_width;
            item_reg.emoji_flag            <= emoji_flag;
            item_reg.unqualified_half_flag <= unqualified_half_flag;
            item_reg.variant_selector_flag <= variant_selector_flag;
        end
    end

    // Segmenter logic.
    gcw_seg_logic u_seg
    (
        .item (item_reg),
        .cur  (trk_reg),
        .cfg  (cfg_reg),
        .nxt  (trk_next),
        .res  (res_next)
    );

    // Segmenter state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_reg.state                <= gcw_pkg::ST_START;
            trk_reg.last_finished_width  <= 3'd0;
            trk_reg.running_width        <= 3'd0;
            trk_reg.running_width_before <= 3'd0;
            trk_reg.pending_unqualified  <= 1'b0;
            trk_reg.pending_wide_special <= 1'b0;
        end
        else if (advance)
        begin
            trk_reg <= trk_next;
        end
    end

    // Result register valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid            = out_valid_reg;
    assign new_grapheme         = res_reg.new_grapheme;
    assign finished_width       = res_reg.finished_width;
    assign current_width        = res_reg.current_width;
    assign current_width_before = res_reg.current_width_before;

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the grapheme cell width tracker. Requests are
// predicted in order by a local copy of the segmenter. Each result is
// compared field by field against the oldest prediction. Random idling runs
// on both channels. Configuration is changed only while the block is idle.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 200000;

    // Clock, reset and every block input start at known values.
    logic              clk                   = 1'b0;
    logic              rst_n                 = 1'b0;
    logic              cfg_write             = 1'b0;
    logic              cfg_index             = 1'b0;
    logic [2:0]        cfg_data              = 3'd0;
    logic              in_valid              = 1'b0;
    logic [20:0]       codepoint             = 21'd0;
    logic signed [2:0] cell_width            = 3'sd0;
    logic              emoji_flag            = 1'b0;
    logic              unqualified_half_flag = 1'b0;
    logic              variant_selector_flag = 1'b0;
    logic              out_stall             = 1'b0;

    logic              in_stall;
    logic              out_valid;
    logic              new_grapheme;
    logic [2:0]        finished_width;
    logic [2:0]        current_width;
    logic [2:0]        current_width_before;

    // Local copy of the segmenter state and its configuration.
    gcw_pkg::tracker_t seg;
    logic [2:0]        ctrl_width_cfg;
    logic              emoji_en_cfg;

    gcw_pkg::result_t expected_widths[$];
    int               mismatches = 0;
    int               sent       = 0;
    int               cycles     = 0;
    logic             quiet      = 1'b0;

    grapheme_cell_width_tracker dut
    (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .cfg_write             (cfg_write),
        .cfg_index             (cfg_index),
        .cfg_data              (cfg_data),
        .in_valid              (in_valid),
        .in_stall              (in_stall),
        .codepoint             (codepoint),
        .cell_width            (cell_width),
        .emoji_flag            (emoji_flag),
        .unqualified_half_flag (unqualified_half_flag),
        .variant_selector_flag (variant_selector_flag),
        .out_valid             (out_valid),
        .out_stall             (out_stall),
        .new_grapheme          (new_grapheme),
        .finished_width        (finished_width),
        .current_width         (current_width),
        .current_width_before  (current_width_before)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    // The receiver stalls at random unless a quiet stretch is running.
    always @(posedge clk)
    begin
        out_stall <= rst_n && !quiet && ($urandom_range(99) < 24);
    end

    // ------------------------------------------------------------------
    // Segmenter prediction
    // ------------------------------------------------------------------

    function automatic gcw_pkg::result_t grapheme_result(input logic started);
        return {started, seg.last_finished_width, seg.running_width,
                seg.running_width_before};
    endfunction

    function automatic void finish_grapheme();
        seg.state                = gcw_pkg::ST_START;
        seg.last_finished_width  = seg.running_width;
        seg.running_width        = 3'd0;
        seg.running_width_before = 3'd0;
    endfunction

    // Widens the current grapheme to at least two cells and keeps its prior width.
    function automatic void widen_current(input logic [2:0] prior);
        seg.running_width_before = prior;
        if (seg.running_width < 3'd2)
            seg.running_width = 3'd2;
    endfunction

    function automatic logic is_regional(input logic [20:0] cp);
        return cp >= gcw_pkg::CP_RI_FIRST && cp <= gcw_pkg::CP_RI_LAST;
    endfunction

    // Advances the segmenter by one request and returns its result.
    function automatic gcw_pkg::result_t segment_codepoint(input gcw_pkg::item_t req);
        logic       ctrl;
        logic [2:0] w;
        logic [2:0] prior;
        logic       seq;
        ctrl  = req.cell_width[2];
        w     = ctrl ? 3'd0 : req.cell_width;
        prior = seg.running_width;
        seq   = 1'b0;

        // A NUL ends the string and stands as a control-width grapheme.
        if (req.codepoint == 21'd0)
        begin
            finish_grapheme();
            seg.running_width = ctrl_width_cfg;
            return grapheme_result(1'b1);
        end

        // Continuation rules of the sequence already under way.
        case (seg.state)
            gcw_pkg::ST_MAYBE_FLAG:
            begin
                seg.state = gcw_pkg::ST_START;
                if (is_regional(req.codepoint))
                begin
                    seg.running_width_before = prior;
                    seg.running_width        = 3'd2;
                    return grapheme_result(1'b0);
                end
            end
            gcw_pkg::ST_BEGIN_EMO:
            begin
                seg.state = gcw_pkg::ST_EMO_SEQ;
                if (seg.pending_unqualified && req.variant_selector_flag)
                begin
                    widen_current(prior);
                    seg.pending_unqualified  = 1'b0;
                    seg.pending_wide_special = 1'b0;
                    return grapheme_result(1'b0);
                end
                if (seg.pending_wide_special)
                    widen_current(prior);
                seq = 1'b1;
            end
            gcw_pkg::ST_EMO_SEQ:
            begin
                seq = 1'b1;
            end
            gcw_pkg::ST_EMO_ZWJ:
            begin
                if (!req.emoji_flag && !req.unqualified_half_flag &&
                    req.codepoint != gcw_pkg::CP_FEMALE &&
                    req.codepoint != gcw_pkg::CP_MALE)
                begin
                    seg.state = gcw_pkg::ST_START;
                end
                else
                begin
                    seg.state = gcw_pkg::ST_EMO_SEQ;
                    return grapheme_result(1'b0);
                end
            end
            gcw_pkg::ST_RUN:
            begin
                if (!ctrl && w == 3'd0)
                    return grapheme_result(1'b0);
                if (emoji_en_cfg && req.variant_selector_flag)
                begin
                    widen_current(prior);
                    return grapheme_result(1'b0);
                end
                seg.state = gcw_pkg::ST_START;
            end
            default:
            begin
                seg.state = gcw_pkg::ST_START;
            end
        endcase

        // Inside an emoji sequence a selector or a joiner extends it.
        if (seq)
        begin
            if (req.variant_selector_flag)
            begin
                widen_current(prior);
                return grapheme_result(1'b0);
            end
            if (req.codepoint == gcw_pkg::CP_ZWJ)
            begin
                widen_current(prior);
                seg.state = gcw_pkg::ST_EMO_ZWJ;
                return grapheme_result(1'b0);
            end
            seg.state = gcw_pkg::ST_START;
        end

        // A new grapheme starts here.
        finish_grapheme();
        if (ctrl)
        begin
            seg.running_width = ctrl_width_cfg;
            return grapheme_result(1'b1);
        end
        seg.running_width = w;

        if (emoji_en_cfg && w != 3'd0)
        begin
            if (is_regional(req.codepoint))
            begin
                seg.state = gcw_pkg::ST_MAYBE_FLAG;
                return grapheme_result(1'b1);
            end
            if (req.unqualified_half_flag || req.emoji_flag)
            begin
                seg.state                = gcw_pkg::ST_BEGIN_EMO;
                seg.pending_unqualified  = req.unqualified_half_flag;
                seg.pending_wide_special = (req.codepoint == gcw_pkg::CP_WAVY_DASH ||
                                            req.codepoint == gcw_pkg::CP_PART_ALT ||
                                            req.codepoint == gcw_pkg::CP_CONGRATS ||
                                            req.codepoint == gcw_pkg::CP_SECRET);
                return grapheme_result(1'b1);
            end
            if (req.variant_selector_flag)
            begin
                if (seg.running_width < 3'd2)
                    seg.running_width = 3'd2;
                seg.state = gcw_pkg::ST_EMO_SEQ;
                return grapheme_result(1'b1);
            end
        end

        seg.state = gcw_pkg::ST_RUN;
        return grapheme_result(1'b1);
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : check_result
        gcw_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_widths.size() == 0)
            begin
                $error("result arrived with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = expected_widths.pop_front();
                if (new_grapheme !== want.new_grapheme)
                begin
                    $error("new_grapheme: expected %0d, actual %0d",
                           want.new_grapheme, new_grapheme);
                    mismatches++;
                end
                if (finished_width !== want.finished_width)
                begin
                    $error("finished_width: expected %0d, actual %0d",
                           want.finished_width, finished_width);
                    mismatches++;
                end
                if (current_width !== want.current_width)
                begin
                    $error("current_width: expected %0d, actual %0d",
                           want.current_width, current_width);
                    mismatches++;
                end
                if (current_width_before !== want.current_width_before)
                begin
                    $error("current_width_before: expected %0d, actual %0d",
                           want.current_width_before, current_width_before);
                    mismatches++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Request and register drivers
    // ------------------------------------------------------------------

    // Sends one request after a random idle gap and predicts its result.
    task automatic send_codepoint(input gcw_pkg::item_t req);
        int gap;
        gap = 0;
        if (!quiet)
            while ($urandom_range(99) < 24)
                gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid              <= 1'b1;
        codepoint             <= req.codepoint;
        cell_width            <= req.cell_width;
        emoji_flag            <= req.emoji_flag;
        unqualified_half_flag <= req.unqualified_half_flag;
        variant_selector_flag <= req.variant_selector_flag;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_widths.push_back(segment_codepoint(req));
        sent++;
    endtask

    // Holds off the sender until every predicted result has come back.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_widths.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Writes one register; the block must be idle.
    task automatic write_reg(input logic idx, input logic [2:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        if (idx == gcw_pkg::CFG_CTRL_WIDTH)
            ctrl_width_cfg = data;
        else
            emoji_en_cfg = data[0];
    endtask

    // ------------------------------------------------------------------
    // Request builders
    // ------------------------------------------------------------------

    function automatic gcw_pkg::item_t mk(input logic [20:0] cp, input logic [2:0] w,
                                          input logic emo, input logic unq,
                                          input logic vs);
        return {cp, w, emo, unq, vs};
    endfunction

    function automatic logic rbit();
        return 1'($urandom_range(1));
    endfunction

    function automatic gcw_pkg::item_t noise_item();
        return mk(21'($urandom_range(32'h10FFFF)), 3'($urandom_range(7)),
                  rbit(), rbit(), rbit());
    endfunction

    function automatic gcw_pkg::item_t vs_item();
        return mk(21'(32'hFE00 + $urandom_range(15)), 3'($urandom_range(1)),
                  1'b0, 1'b0, 1'b1);
    endfunction

    function automatic gcw_pkg::item_t emoji_item();
        return mk(21'(32'h1F300 + $urandom_range(32'h7FF)),
                  3'(1 + $urandom_range(1)), 1'b1, rbit(), 1'b0);
    endfunction

    function automatic gcw_pkg::item_t ri_item();
        return mk(21'($urandom_range(gcw_pkg::CP_RI_FIRST, gcw_pkg::CP_RI_LAST)),
                  3'(1 + $urandom_range(1)), rbit(), 1'b0, 1'b0);
    endfunction

    // One well-formed or broken sequence with random content.
    task automatic send_sequence();
        int          kind;
        int          links;
        logic [20:0] special;
        kind = $urandom_range(9);
        case (kind)
            // Flag pair, sometimes broken by a stray codepoint.
            0:
            begin
                send_codepoint(ri_item());
                if ($urandom_range(3) != 0)
                    send_codepoint(ri_item());
                else
                    send_codepoint(noise_item());
            end
            // Emoji with optional selector and a chain of joiners.
            1, 2:
            begin
                send_codepoint(emoji_item());
                if (rbit())
                    send_codepoint(vs_item());
                links = $urandom_range(3);
                repeat (links)
                begin
                    send_codepoint(mk(gcw_pkg::CP_ZWJ, 3'd0, 1'b0, 1'b0, 1'b0));
                    case ($urandom_range(3))
                        0: send_codepoint(mk(rbit() ? gcw_pkg::CP_FEMALE
                                                    : gcw_pkg::CP_MALE,
                                             3'd1, 1'b0, 1'b0, 1'b0));
                        1: send_codepoint(noise_item());
                        default: send_codepoint(emoji_item());
                    endcase
                    if ($urandom_range(2) == 0)
                        send_codepoint(vs_item());
                end
            end
            // Possibly unqualified half-width emoji, usually qualified.
            3:
            begin
                send_codepoint(mk(21'(32'h2000 + $urandom_range(32'hBFF)),
                                  3'(1 + $urandom_range(1)), rbit(), 1'b1, 1'b0));
                if ($urandom_range(3) != 0)
                    send_codepoint(vs_item());
                else
                    send_codepoint(noise_item());
            end
            // The four special codepoints that widen when they open an emoji sequence.
            4:
            begin
                case ($urandom_range(3))
                    0: special = gcw_pkg::CP_WAVY_DASH;
                    1: special = gcw_pkg::CP_PART_ALT;
                    2: special = gcw_pkg::CP_CONGRATS;
                    default: special = gcw_pkg::CP_SECRET;
                endcase
                send_codepoint(mk(special, 3'(1 + $urandom_range(1)),
                                  rbit(), rbit(), 1'b0));
                case ($urandom_range(2))
                    0: send_codepoint(vs_item());
                    1: send_codepoint(mk(gcw_pkg::CP_ZWJ, 3'd0, 1'b0, 1'b0, 1'b0));
                    default: send_codepoint(noise_item());
                endcase
            end
            // Base character, or a zero-width start, with marks after it.
            5, 6:
            begin
                send_codepoint(mk(21'(32'h20 + $urandom_range(32'hFFDF)),
                                  3'($urandom_range(2)), 1'b0, 1'b0, 1'b0));
                links = $urandom_range(3);
                repeat (links)
                    send_codepoint(mk(21'(32'h300 + $urandom_range(32'h6F)),
                                      3'd0, 1'b0, 1'b0, 1'b0));
                if (rbit())
                    send_codepoint(vs_item());
            end
            // Control characters and NUL.
            7:
            begin
                if (rbit())
                    send_codepoint(mk(21'd0, 3'($urandom_range(7)),
                                      rbit(), rbit(), rbit()));
                else
                    send_codepoint(mk(21'($urandom_range(1, 31)),
                                      3'(4 + $urandom_range(3)),
                                      rbit(), rbit(), rbit()));
            end
            default:
            begin
                links = 1 + $urandom_range(2);
                repeat (links)
                    send_codepoint(noise_item());
            end
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and every special case at the reset configuration.
    task automatic test_directed();
        // Plain run, zero-width followers, selector widening in a run.
        send_codepoint(mk(21'h00041, 3'd1, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h00301, 3'd0, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h0FE0F, 3'd0, 1'b0, 1'b0, 1'b1));
        send_codepoint(mk(21'h0FE0E, 3'd1, 1'b0, 1'b0, 1'b1));
        // NUL, then control characters whose emoji flags are ignored.
        send_codepoint(mk(21'h00000, 3'd2, 1'b1, 1'b1, 1'b1));
        send_codepoint(mk(21'h00007, 3'b111, 1'b1, 1'b1, 1'b1));
        send_codepoint(mk(21'h0001F, 3'b100, 1'b0, 1'b0, 1'b0));
        // Zero-width start, then a width of three.
        send_codepoint(mk(21'h0200B, 3'd0, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h0200C, 3'd0, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h12345, 3'd3, 1'b0, 1'b0, 1'b0));
        // Flag pair at both range ends, then a lone indicator.
        send_codepoint(mk(gcw_pkg::CP_RI_FIRST, 3'd1, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(gcw_pkg::CP_RI_LAST, 3'd1, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h1F1FA, 3'd1, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h00042, 3'd1, 1'b0, 1'b0, 1'b0));
        // Emoji, selector, joiner and gender sign; then a broken joiner.
        send_codepoint(mk(21'h1F600, 3'd2, 1'b1, 1'b0, 1'b0));
        send_codepoint(mk(21'h0FE0F, 3'd0, 1'b0, 1'b0, 1'b1));
        send_codepoint(mk(gcw_pkg::CP_ZWJ, 3'd0, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(gcw_pkg::CP_FEMALE, 3'd1, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(gcw_pkg::CP_ZWJ, 3'd0, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h00043, 3'd1, 1'b0, 1'b0, 1'b0));
        // Unqualified emoji qualified by a selector.
        send_codepoint(mk(21'h0263A, 3'd1, 1'b0, 1'b1, 1'b0));
        send_codepoint(mk(21'h0FE0F, 3'd0, 1'b0, 1'b0, 1'b1));
        // Wide special emoji, alone and joined.
        send_codepoint(mk(gcw_pkg::CP_WAVY_DASH, 3'd1, 1'b0, 1'b1, 1'b0));
        send_codepoint(mk(21'h00044, 3'd1, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(gcw_pkg::CP_SECRET, 3'd1, 1'b1, 1'b0, 1'b0));
        send_codepoint(mk(gcw_pkg::CP_ZWJ, 3'd0, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(gcw_pkg::CP_MALE, 3'd1, 1'b0, 1'b0, 1'b0));
        // Selector starting a grapheme, the top codepoint, other specials.
        send_codepoint(mk(21'h0FE0F, 3'd1, 1'b0, 1'b0, 1'b1));
        send_codepoint(mk(21'h10FFFF, 3'd2, 1'b1, 1'b1, 1'b1));
        send_codepoint(mk(gcw_pkg::CP_PART_ALT, 3'd1, 1'b0, 1'b1, 1'b0));
        send_codepoint(mk(gcw_pkg::CP_CONGRATS, 3'd1, 1'b1, 1'b1, 1'b0));
        wait_for_results();
    endtask

    // Both register extremes: narrow control width with emoji parsing off,
    // then the widest control width with it on.
    task automatic test_config_extremes();
        write_reg(gcw_pkg::CFG_CTRL_WIDTH, 3'd0);
        write_reg(gcw_pkg::CFG_EMOJI_EN, 3'd0);
        send_codepoint(mk(21'h00000, 3'd0, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h0001B, 3'b111, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(gcw_pkg::CP_RI_FIRST, 3'd1, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h1F1EA, 3'd1, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h1F600, 3'd2, 1'b1, 1'b0, 1'b0));
        send_codepoint(mk(21'h0FE0F, 3'd1, 1'b0, 1'b0, 1'b1));
        send_codepoint(mk(21'h0FE0F, 3'd1, 1'b0, 1'b0, 1'b1));
        wait_for_results();
        write_reg(gcw_pkg::CFG_CTRL_WIDTH, 3'd7);
        write_reg(gcw_pkg::CFG_EMOJI_EN, 3'd1);
        send_codepoint(mk(21'h00000, 3'd1, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h0007F, 3'b110, 1'b1, 1'b0, 1'b0));
        send_codepoint(mk(21'h00045, 3'd1, 1'b0, 1'b0, 1'b0));
        wait_for_results();
    endtask

    // A parse under way carries on when emoji parsing is switched off.
    task automatic test_config_mid_sequence();
        write_reg(gcw_pkg::CFG_CTRL_WIDTH, 3'd1);
        send_codepoint(mk(21'h1F44D, 3'd2, 1'b1, 1'b0, 1'b0));
        wait_for_results();
        write_reg(gcw_pkg::CFG_EMOJI_EN, 3'd0);
        send_codepoint(mk(21'h0FE0F, 3'd0, 1'b0, 1'b0, 1'b1));
        send_codepoint(mk(gcw_pkg::CP_ZWJ, 3'd0, 1'b0, 1'b0, 1'b0));
        wait_for_results();
        write_reg(gcw_pkg::CFG_EMOJI_EN, 3'd1);
        send_codepoint(mk(21'h1F1EF, 3'd1, 1'b0, 1'b0, 1'b0));
        wait_for_results();
        write_reg(gcw_pkg::CFG_EMOJI_EN, 3'd0);
        send_codepoint(mk(21'h1F1F5, 3'd1, 1'b0, 1'b0, 1'b0));
        send_codepoint(mk(21'h1F469, 3'd2, 1'b1, 1'b0, 1'b0));
        wait_for_results();
    endtask

    // One random phase at a given setting, with a full drain halfway.
    task automatic run_random_phase(input logic [2:0] ctrl_w, input logic emoji_en,
                                    input logic burst, input int count);
        int target;
        write_reg(gcw_pkg::CFG_CTRL_WIDTH, ctrl_w);
        write_reg(gcw_pkg::CFG_EMOJI_EN, {2'b00, emoji_en});
        quiet  = burst;
        target = sent + count / 2;
        while (sent < target)
            send_sequence();
        wait_for_results();
        target = sent + count - count / 2;
        while (sent < target)
            send_sequence();
        wait_for_results();
        quiet = 1'b0;
    endtask

    task automatic test_random();
        run_random_phase(3'd7, 1'b1, 1'b0, 230);
        run_random_phase(3'd0, 1'b0, 1'b0, 230);
        run_random_phase(3'd1, 1'b1, 1'b1, 230);
        run_random_phase(3'($urandom_range(7)), rbit(), 1'b0, 230);
    endtask

    initial
    begin
        seg            = '0;
        ctrl_width_cfg = 3'd1;
        emoji_en_cfg   = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_config_mid_sequence();
        test_random();

        wait_for_results();
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
